### rtl/core/brb_pkg.sv
package brb_pkg;

  // Operation codes as they arrive on the input channel.
  localparam logic [1:0] OP_PUT  = 2'd0;
  localparam logic [1:0] OP_GET  = 2'd1;
  localparam logic [1:0] OP_PEEK = 2'd2;

  // Kind of work the back end has to carry out for one queued item.
  typedef enum logic [1:0] {
    KIND_PUT,
    KIND_GET,
    KIND_PEEK,
    KIND_NOP
  } kind_t;

  // One classified item as it travels from the front to the back end.
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  count;
    logic [7:0]  data;
    logic        run_last;
  } cmd_t;

  // Back end sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DATA = 2'b10
  } back_state_t;

endpackage

### rtl/core/brb_ram.sv
module brb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port; read data holds while re is low.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/brb_front.sv
module brb_front import brb_pkg::*; #(
  parameter int MAX_READ = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_operation,
  input  logic [7:0] in_count,
  input  logic [7:0] in_data,
  input  logic       in_run_last,
  output cmd_t       q_cmd,
  output logic       q_valid,
  input  logic       q_pop
);

  cmd_t       cls;
  cmd_t       q_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] level_r;
  logic [1:0] level_nxt;
  logic       push;

  // Classify the incoming item and clip read requests to the burst limit.
  always_comb begin
    cls.count    = in_count;
    cls.data     = in_data;
    cls.run_last = in_run_last;
    case (in_operation)
      OP_PUT:  cls.kind = KIND_PUT;
      OP_GET:  cls.kind = KIND_GET;
      OP_PEEK: cls.kind = KIND_PEEK;
      default: cls.kind = KIND_NOP;
    endcase
    if ((in_operation inside {OP_GET, OP_PEEK}) && (in_count > 8'(MAX_READ))) begin
      cls.count = 8'(MAX_READ);
    end
  end

  // Two-entry queue toward the back end.
  assign in_stall = (level_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (level_r != 2'd0);
  assign q_cmd    = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push  ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? !rd_ptr_r : rd_ptr_r;
    case ({push, q_pop})
      2'b10:   level_nxt = level_r + 2'd1;
      2'b01:   level_nxt = level_r - 2'd1;
      default: level_nxt = level_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      level_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

endmodule

### rtl/core/brb_back.sv
module brb_back import brb_pkg::*; #(
  parameter int DEPTH    = 256,
  parameter int MAX_READ = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_write_en,
  input  logic [8:0] cfg_buffer_length,
  input  cmd_t       q_cmd,
  input  logic       q_valid,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_data_out,
  output logic       out_has_data,
  output logic [7:0] out_returned_count,
  output logic       out_last
);

  localparam int PW        = $clog2(DEPTH);
  localparam int LW        = $clog2(DEPTH + 1);
  localparam int CW        = (LW > 9) ? LW : 9;
  localparam int SW        = CW + 1;
  localparam int RW        = $clog2(MAX_READ + 1);
  localparam int RESET_LEN = (DEPTH < 256) ? DEPTH : 256;

  back_state_t   state_r;
  back_state_t   state_nxt;
  logic [LW-1:0] len_r;
  logic [LW-1:0] len_cfg;
  logic [CW-1:0] cfg_ext;
  logic [PW-1:0] head_r;
  logic [PW-1:0] head_nxt;
  logic [PW-1:0] tail_r;
  logic [PW-1:0] tail_nxt;
  logic [PW-1:0] fill_r;
  logic [PW-1:0] fill_nxt;
  logic          in_run_r;
  logic          in_run_nxt;
  logic          run_acc_r;
  logic          run_acc_nxt;
  logic [PW-1:0] rd_idx_r;
  logic [PW-1:0] rd_idx_nxt;
  logic [RW-1:0] remain_r;
  logic [RW-1:0] remain_nxt;
  logic [RW-1:0] n_r;
  logic [RW-1:0] n_nxt;
  logic          is_get_r;
  logic          is_get_nxt;

  logic          out_valid_r;
  logic [7:0]    out_data_r;
  logic          out_has_r;
  logic [7:0]    out_cnt_r;
  logic          out_last_r;

  logic          slot_free;
  logic          load;
  logic [7:0]    ld_data;
  logic          ld_has;
  logic [7:0]    ld_cnt;
  logic          ld_last;
  logic          put_acc;
  logic [RW-1:0] get_n;
  logic [PW-1:0] next_idx;

  logic          ram_we;
  logic          ram_re;
  logic [PW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  // Step a ring index, wrapping at the programmed length.
  function automatic logic [PW-1:0] adv(input logic [PW-1:0] idx,
                                        input logic [LW-1:0] len);
    logic [LW:0] inc;
    inc = {{(LW + 1 - PW){1'b0}}, idx} + 1'b1;
    if (inc >= {1'b0, len}) begin
      adv = '0;
    end else begin
      adv = PW'(inc);
    end
  endfunction

  brb_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_r),
    .wdata (q_cmd.data),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Saturate the written length to the legal slot range.
  always_comb begin
    cfg_ext = CW'(cfg_buffer_length);
    if (cfg_ext < CW'(2)) begin
      len_cfg = LW'(2);
    end else if (cfg_ext > CW'(DEPTH)) begin
      len_cfg = LW'(DEPTH);
    end else begin
      len_cfg = LW'(cfg_ext);
    end
  end

  assign slot_free = !out_valid_r || !out_stall;

  // Sequencer: puts complete in the idle state; reads stream one byte per cycle while the output slot is free.
  always_comb begin
    state_nxt   = state_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    fill_nxt    = fill_r;
    in_run_nxt  = in_run_r;
    run_acc_nxt = run_acc_r;
    rd_idx_nxt  = rd_idx_r;
    remain_nxt  = remain_r;
    n_nxt       = n_r;
    is_get_nxt  = is_get_r;
    q_pop       = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = head_r;
    load        = 1'b0;
    ld_data     = 8'd0;
    ld_has      = 1'b0;
    ld_cnt      = 8'd0;
    ld_last     = 1'b1;
    put_acc     = in_run_r ? run_acc_r
                : ((q_cmd.count != 8'd0) &&
                   ((SW'(fill_r) + SW'(q_cmd.count)) < SW'(len_r)));
    get_n       = (SW'(fill_r) < SW'(q_cmd.count)) ? RW'(fill_r) : RW'(q_cmd.count);
    next_idx    = adv(rd_idx_r, len_r);

    case (state_r)
      ST_IDLE: begin
        if (q_valid && slot_free) begin
          q_pop = 1'b1;
          case (q_cmd.kind)
            KIND_PUT: begin
              // The run verdict is taken on its first byte; a full ring drops the byte.
              if (put_acc && ((SW'(fill_r) + SW'(1)) < SW'(len_r))) begin
                ram_we   = 1'b1;
                tail_nxt = adv(tail_r, len_r);
                fill_nxt = fill_r + 1'b1;
              end
              if (q_cmd.run_last) begin
                load        = 1'b1;
                ld_cnt      = put_acc ? q_cmd.count : 8'd0;
                in_run_nxt  = 1'b0;
                run_acc_nxt = 1'b0;
              end else begin
                in_run_nxt  = 1'b1;
                run_acc_nxt = put_acc;
              end
            end
            KIND_GET, KIND_PEEK: begin
              if (get_n == '0) begin
                load = 1'b1;
              end else begin
                n_nxt      = get_n;
                remain_nxt = get_n;
                rd_idx_nxt = head_r;
                is_get_nxt = (q_cmd.kind == KIND_GET);
                ram_re     = 1'b1;
                ram_raddr  = head_r;
                state_nxt  = ST_DATA;
              end
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      ST_DATA: begin
        // Hand the fetched byte over and prefetch the next one.
        if (slot_free) begin
          load    = 1'b1;
          ld_data = ram_rdata;
          ld_has  = 1'b1;
          ld_cnt  = 8'(n_r);
          ld_last = (remain_r == RW'(1));
          if (remain_r == RW'(1)) begin
            if (is_get_r) begin
              head_nxt = next_idx;
              fill_nxt = fill_r - PW'(n_r);
            end
            state_nxt = ST_IDLE;
          end else begin
            remain_nxt = remain_r - 1'b1;
            rd_idx_nxt = next_idx;
            ram_re     = 1'b1;
            ram_raddr  = next_idx;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state; a length write clears the ring pointers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= LW'(RESET_LEN);
      head_r      <= '0;
      tail_r      <= '0;
      fill_r      <= '0;
      in_run_r    <= 1'b0;
      run_acc_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_write_en) begin
        len_r     <= len_cfg;
        head_r    <= '0;
        tail_r    <= '0;
        fill_r    <= '0;
        in_run_r  <= 1'b0;
        run_acc_r <= 1'b0;
      end else begin
        head_r    <= head_nxt;
        tail_r    <= tail_nxt;
        fill_r    <= fill_nxt;
        in_run_r  <= in_run_nxt;
        run_acc_r <= run_acc_nxt;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Read burst bookkeeping and the output register payload.
  always_ff @(posedge clk) begin
    rd_idx_r <= rd_idx_nxt;
    remain_r <= remain_nxt;
    n_r      <= n_nxt;
    is_get_r <= is_get_nxt;
    if (load) begin
      out_data_r <= ld_data;
      out_has_r  <= ld_has;
      out_cnt_r  <= ld_cnt;
      out_last_r <= ld_last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_data_out       = out_data_r;
  assign out_has_data       = out_has_r;
  assign out_returned_count = out_cnt_r;
  assign out_last           = out_last_r;

endmodule

### rtl/core/byte_ring_buffer_unit.sv
// Byte ring buffer with a programmable length.
// Input channel (in_valid / in_stall): one item per put byte, get request or
// peek request. A put run is accepted or dropped as a whole on its first byte;
// its last byte returns one result with the number of bytes taken. Get and
// peek return one result per byte, up to the burst limit, and a single empty
// result when nothing can be read. Unused operation codes return an empty result.
// Result channel (out_valid / out_stall): one registered result per handshake.
// Items pass a two-entry queue before the back end executes them. A put byte
// is handled in the back end idle state; a put result passes the queue entry and
// then the result register. A get or peek issues its first read of the byte store
// in the cycle it leaves the queue and then delivers one byte per cycle while the
// receiver does not stall; each byte passes the byte store read register and then
// the result register, and the back end takes no new item until the read is done.
// Read bursts run one at a time, bound by the single read port of the byte store.
// When the receiver stalls, the result stays on the port unchanged, the back
// end halts, and the input keeps taking items until the queue is full.
// Reset sets the length to 256 slots (capped at DEPTH) and empties the ring;
// writing cfg_buffer_length saturates it to 2..DEPTH and empties the ring.
// The byte store itself is not cleared.
module byte_ring_buffer_unit import brb_pkg::*; #(
  parameter int DEPTH    = 256,
  parameter int MAX_READ = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_write_en,
  input  logic [8:0] cfg_buffer_length,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_operation,
  input  logic [7:0] in_count,
  input  logic [7:0] in_data,
  input  logic       in_run_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_data_out,
  output logic       out_has_data,
  output logic [7:0] out_returned_count,
  output logic       out_last
);

  cmd_t q_cmd;
  logic q_valid;
  logic q_pop;

  // Front end: accept and classify items into the queue.
  brb_front #(
    .MAX_READ (MAX_READ)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_count     (in_count),
    .in_data      (in_data),
    .in_run_last  (in_run_last),
    .q_cmd        (q_cmd),
    .q_valid      (q_valid),
    .q_pop        (q_pop)
  );

  // Back end: ring state, byte store and result register.
  brb_back #(
    .DEPTH    (DEPTH),
    .MAX_READ (MAX_READ)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_write_en       (cfg_write_en),
    .cfg_buffer_length  (cfg_buffer_length),
    .q_cmd              (q_cmd),
    .q_valid            (q_valid),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_data_out       (out_data_out),
    .out_has_data       (out_has_data),
    .out_returned_count (out_returned_count),
    .out_last           (out_last)
  );

endmodule
